/* rtl/d2d_pkg.sv */
// Shared types and constants for the disparity-to-depth feature init block.
// No dependencies; imported by the divider, multiplier and top level.
`timescale 1ns / 1ps

package d2d_pkg;

  // Feature count limits
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned MAX_FEATURES = 256;
  localparam logic [CNT_W-1:0] FEATURE_CAP =
    (MAX_FEATURES > ((1 << CNT_W) - 1)) ? {CNT_W{1'b1}} : CNT_W'(MAX_FEATURES);

  // Fixed field widths
  localparam int unsigned DISP_W  = 16;
  localparam int unsigned FB_W    = 32;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned VAR_W   = 48;

  // Scale factor applied to the disparity step, and its product width
  localparam int unsigned SCALE_CONST = 1000;
  localparam int unsigned K_W         = 26;

  // Shared iterative divider: quotient bits and divisor/remainder width
  localparam int unsigned DIV_QW = 32;
  localparam int unsigned DIV_DW = 40;

  // Shared multiplier operand width
  localparam int unsigned MUL_W = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DISP = 2'd1,
    STATUS_ENOUGH   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_FOCAL_BASELINE = 3'd0,
    CFG_MIN_DISPARITY  = 3'd1,
    CFG_MAX_DISPARITY  = 3'd2,
    CFG_DISPARITY_STEP = 3'd3
  } cfg_reg_e;

  localparam logic [FB_W-1:0]          FB_RESET   = 32'd5505024;
  localparam logic signed [DISP_W-1:0] MIN_RESET  = 16'sd0;
  localparam logic signed [DISP_W-1:0] MAX_RESET  = 16'sd32767;
  localparam logic [STEP_W-1:0]        STEP_RESET = 16'd16;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] rem_init;
    logic [DIV_QW-1:0] dividend_lo;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/d2d_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on d2d_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module d2d_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  d2d_pkg::div_req_t             req_i,
  output d2d_pkg::div_stat_t            stat_o,
  output logic [d2d_pkg::DIV_QW-1:0]    quot_o
);
  import d2d_pkg::*;

  localparam int unsigned CW = $clog2(DIV_QW + 1);

  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_QW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] den_q;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // Remainder stays below the divisor, so one shifted-in bit fits DIV_DW+1 bits
  always_comb begin
    trial = {rem_q, quo_q[DIV_QW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    quo_d = {quo_q[DIV_QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      // flag the cycle right after the last quotient bit lands
      done_q <= !req_i.start && (cnt_q == CW'(1));
      if (req_i.start) begin
        cnt_q <= CW'(DIV_QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      quo_q <= req_i.dividend_lo;
      den_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

/* rtl/d2d_mult.sv */
// Shared unsigned multiplier with a registered product.
// Depends on d2d_pkg for the operand width.
`timescale 1ns / 1ps

module d2d_mult (
  input  logic                           clk_i,
  input  logic [d2d_pkg::MUL_W-1:0]      a_i,
  input  logic [d2d_pkg::MUL_W-1:0]      b_i,
  output logic [2*d2d_pkg::MUL_W-1:0]    p_o
);
  import d2d_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* rtl/disparity_to_depth_feature_init_core.sv */
// Top level of the disparity-to-depth feature init block: sequencer,
// configuration registers and result register. Depends on d2d_pkg,
// d2d_div and d2d_mult.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one candidate point per
//   transaction. frame_start_i reloads the count of features still needed
//   (clamped to the feature cap) before the candidate is judged.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result per
//   candidate: status, depth, depth variance, echoed position, count left.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; write only
//   while no candidate is in flight. Unknown indexes are dropped.
// Sequencing:
//   A candidate that needs no math (bad disparity, enough features, or zero
//   focal_baseline) goes from idle straight to the done state and from there
//   to the result register. Every other candidate makes two passes through
//   the shared one-bit-per-cycle divider (depth, then std deviation) plus
//   four trips through the shared registered multiplier; a saturated depth
//   skips the depth pass, and a saturated deviation skips the deviation
//   pass and the last multiply. in_ready_o is high only while the sequencer
//   is idle, so one candidate is worked on at a time; the result register
//   lets the next candidate start while a finished result still waits.
// Reset and stalls:
//   Reset loads the register defaults, clears the needed count and empties
//   the result register. If the receiver stalls, the finished result holds
//   in the sequencer until the result register frees up.
`timescale 1ns / 1ps

module disparity_to_depth_feature_init_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [d2d_pkg::FB_W-1:0]             cfg_data_i,
  // candidate input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [d2d_pkg::DISP_W-1:0]    disparity_i,
  input  logic [d2d_pkg::POS_W-1:0]            pos_x_i,
  input  logic [d2d_pkg::POS_W-1:0]            pos_y_i,
  input  logic                                 frame_start_i,
  input  logic [d2d_pkg::CNT_W-1:0]            needed_count_i,
  // result output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [d2d_pkg::DEPTH_W-1:0]          depth_o,
  output logic [d2d_pkg::VAR_W-1:0]            depth_variance_o,
  output logic [d2d_pkg::POS_W-1:0]            out_x_o,
  output logic [d2d_pkg::POS_W-1:0]            out_y_o,
  output logic [d2d_pkg::CNT_W-1:0]            remaining_o
);
  import d2d_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_Z,
    ST_MUL_ZZ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_S,
    ST_MUL_SS,
    ST_VAR,
    ST_DONE
  } state_e;

  localparam int unsigned P0_W  = MUL_W + K_W;      // 32x26 partial product
  localparam int unsigned UP_W  = P0_W;             // product bits above 32
  localparam logic [VAR_W-1:0] VAR_SAT = {VAR_W{1'b1}};
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = {DEPTH_W{1'b1}};

  // configuration registers
  logic [FB_W-1:0]          fb_q;
  logic signed [DISP_W-1:0] min_q, max_q;
  logic [STEP_W-1:0]        step_q;

  // sequencer and working registers
  state_e               state_q;
  logic [CNT_W-1:0]     remaining_q;
  status_e              res_status_q;
  logic [CNT_W-1:0]     res_rem_q;
  logic [POS_W-1:0]     res_x_q, res_y_q;
  logic [DEPTH_W-1:0]   z_q;
  logic [VAR_W-1:0]     var_q;
  logic [K_W-1:0]       k_q;
  logic [MUL_W-1:0]     zz_hi_q, s_q;
  logic [P0_W-1:0]      p0_q;

  // result register
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [DEPTH_W-1:0]   out_depth_q;
  logic [VAR_W-1:0]     out_var_q;
  logic [POS_W-1:0]     out_x_q, out_y_q;
  logic [CNT_W-1:0]     out_rem_q;

  // shared units
  div_req_t             div_req;
  div_stat_t            div_stat;
  logic [DIV_QW-1:0]    div_quot;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;

  // candidate judgement
  logic                 in_fire;
  logic [CNT_W-1:0]     cnt_load, rem_new;
  logic                 disp_ok;
  status_e              status_new;
  logic                 do_math, sat_z;
  logic [K_W-1:0]       k_new;

  // variance product assembly
  logic [UP_W-1:0]      prod_up;
  logic                 sat_s;

  d2d_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  d2d_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // Judge the candidate against the count and the disparity window
  always_comb begin
    if (frame_start_i) begin
      cnt_load = (needed_count_i > FEATURE_CAP) ? FEATURE_CAP : needed_count_i;
    end else begin
      cnt_load = remaining_q;
    end
    disp_ok = (disparity_i > min_q) && (disparity_i < max_q) && (disparity_i > 16'sd0);
    rem_new = cnt_load;
    if (cnt_load == '0) begin
      status_new = STATUS_ENOUGH;
    end else if (disp_ok) begin
      status_new = STATUS_OK;
      rem_new    = cnt_load - 1'b1;
    end else begin
      status_new = STATUS_BAD_DISP;
    end
    do_math = (status_new == STATUS_OK) && (fb_q != '0);
    // depth overflows 32 bits when the top byte of fT*256 reaches d
    sat_z   = {8'h00, fb_q[FB_W-1:FB_W-8]} >= $unsigned(disparity_i);
    k_new   = K_W'(step_q * SCALE_CONST);
  end

  // Upper part of z*z*k = p0 + (p1 << 32); saturate when the quotient
  // would need more than 32 bits
  always_comb begin
    prod_up = UP_W'(p0_q[P0_W-1:MUL_W]) + mul_p[UP_W-1:0];
    sat_s   = prod_up >= UP_W'({fb_q, 8'h00});
  end

  // Divider requests: depth in idle, std deviation after the product sum
  always_comb begin
    div_req = '0;
    if (state_q == ST_IDLE) begin
      div_req.start       = in_fire && do_math && !sat_z;
      div_req.rem_init    = DIV_DW'(fb_q[FB_W-1:FB_W-8]);
      div_req.dividend_lo = {fb_q[FB_W-9:0], 8'h00};
      div_req.divisor     = DIV_DW'(disparity_i[DISP_W-2:0]);
    end else if (state_q == ST_SUM) begin
      div_req.start       = !sat_s;
      div_req.rem_init    = prod_up[DIV_DW-1:0];
      div_req.dividend_lo = p0_q[MUL_W-1:0];
      div_req.divisor     = {fb_q, 8'h00};
    end
  end

  // Multiplier operand select
  always_comb begin
    case (state_q)
      ST_MUL_ZZ: begin
        mul_a = z_q;
        mul_b = z_q;
      end
      ST_MUL_LO: begin
        mul_a = mul_p[MUL_W-1:0];
        mul_b = MUL_W'(k_q);
      end
      ST_MUL_HI: begin
        mul_a = zz_hi_q;
        mul_b = MUL_W'(k_q);
      end
      ST_MUL_SS: begin
        mul_a = s_q;
        mul_b = s_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q   <= FB_RESET;
      min_q  <= MIN_RESET;
      max_q  <= MAX_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FOCAL_BASELINE: fb_q   <= cfg_data_i;
        CFG_MIN_DISPARITY:  min_q  <= cfg_data_i[DISP_W-1:0];
        CFG_MAX_DISPARITY:  max_q  <= cfg_data_i[DISP_W-1:0];
        CFG_DISPARITY_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with working and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remaining_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once the receiver takes it, unless a new one loads
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            remaining_q  <= rem_new;
            res_status_q <= status_new;
            res_rem_q    <= rem_new;
            res_x_q      <= pos_x_i;
            res_y_q      <= pos_y_i;
            k_q          <= k_new;
            var_q        <= '0;
            if (!do_math) begin
              z_q     <= '0;
              state_q <= ST_DONE;
            end else if (sat_z) begin
              z_q     <= DEPTH_SAT;
              state_q <= ST_MUL_ZZ;
            end else begin
              z_q     <= '0;
              state_q <= ST_DIV_Z;
            end
          end
        end
        ST_DIV_Z: begin
          if (div_stat.done) begin
            z_q     <= div_quot;
            state_q <= ST_MUL_ZZ;
          end
        end
        ST_MUL_ZZ: begin
          state_q <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          zz_hi_q <= mul_p[2*MUL_W-1:MUL_W];
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          p0_q    <= mul_p[P0_W-1:0];
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (sat_s) begin
            var_q   <= VAR_SAT;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DIV_S;
          end
        end
        ST_DIV_S: begin
          if (div_stat.done) begin
            s_q     <= div_quot;
            state_q <= ST_MUL_SS;
          end
        end
        ST_MUL_SS: begin
          state_q <= ST_VAR;
        end
        ST_VAR: begin
          var_q   <= mul_p[2*MUL_W-1:2*MUL_W-VAR_W];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_depth_q  <= z_q;
            out_var_q    <= var_q;
            out_x_q      <= res_x_q;
            out_y_q      <= res_y_q;
            out_rem_q    <= res_rem_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign depth_o          = out_depth_q;
  assign depth_variance_o = out_var_q;
  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign remaining_o      = out_rem_q;

  // Assertions
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after taking a candidate");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> depth_o == '0 && depth_variance_o == '0)
    else $error("rejected candidate carries nonzero depth or variance");

  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q <= FEATURE_CAP)
    else $error("needed count above the feature cap");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_o && !out_ready_i |=> state_q == ST_DONE)
    else $error("finished result overwrote a pending one");

endmodule
